// ===== design/utc_pkg.sv =====
package utc_pkg;

    localparam int CP_W = 21;

    localparam logic [5:0]      SURR_HI_TAG = 6'b110110;
    localparam logic [5:0]      SURR_LO_TAG = 6'b110111;
    localparam logic [CP_W-1:0] SUPP_BASE   = 21'h10000;

    localparam logic [15:0] CP1252_MAP [32] = '{
        16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
        16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_out;
    } t_out_item;

    // Up to two code points per request; cp_b is used only when cp_a is.
    // No code point with last set is a bare end marker.
    typedef struct packed {
        logic [CP_W-1:0] cp_a;
        logic            has_a;
        logic [CP_W-1:0] cp_b;
        logic            has_b;
        logic            last;
    } t_job;

    function automatic logic [CP_W-1:0] cp1252_to_cp(input logic [7:0] b);
        logic [15:0] m;
        m = CP1252_MAP[b[4:0]];
        if (b[7:5] == 3'b100 && m != 16'h0000) begin
            return {5'b0, m};
        end
        return {13'b0, b};
    endfunction

    // Number of UTF-8 bytes minus one.
    function automatic logic [1:0] utf8_len_m1(input logic [CP_W-1:0] cp);
        if (cp[CP_W-1:7] == '0) begin
            return 2'd0;
        end else if (cp[CP_W-1:11] == '0) begin
            return 2'd1;
        end else if (cp[CP_W-1:16] == '0) begin
            return 2'd2;
        end
        return 2'd3;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [1:0]      idx);
        logic [7:0] r;
        r = {2'b10, cp[5:0]};
        unique case (utf8_len_m1(cp))
            2'd0: r = {1'b0, cp[6:0]};
            2'd1: begin
                if (idx == 2'd0) r = {3'b110, cp[10:6]};
            end
            2'd2: begin
                if (idx == 2'd0)      r = {4'b1110, cp[15:12]};
                else if (idx == 2'd1) r = {2'b10, cp[11:6]};
            end
            default: begin
                if (idx == 2'd0)      r = {5'b11110, cp[20:18]};
                else if (idx == 2'd1) r = {2'b10, cp[17:12]};
                else if (idx == 2'd2) r = {2'b10, cp[11:6]};
            end
        endcase
        return r;
    endfunction

endpackage

// ===== design/utc_front.sv =====
module utc_front import utc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_job     o_q_job
);

    logic       r_src_enc;
    logic [7:0] r_held_low;
    logic       r_have_low;
    logic [9:0] r_pend;
    logic       r_have_pend;

    logic [7:0] n_held_low;
    logic       n_have_low;
    logic [9:0] n_pend;
    logic       n_have_pend;

    logic            accept;
    logic            last;
    logic [15:0]     unit;
    logic            is_hi;
    logic            is_lo;
    logic [CP_W-1:0] pend_cp;
    logic [CP_W-1:0] comb_cp;
    t_job            job;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign last       = i_in_data.last_in;
    assign unit       = {i_in_data.in_byte, r_held_low};
    assign is_hi      = unit[15:10] == SURR_HI_TAG;
    assign is_lo      = unit[15:10] == SURR_LO_TAG;
    assign pend_cp    = {5'b0, SURR_HI_TAG, r_pend};
    assign comb_cp    = SUPP_BASE + {1'b0, r_pend, unit[9:0]};

    always_comb begin
        job         = '0;
        job.last    = last;
        n_held_low  = r_held_low;
        n_have_low  = r_have_low;
        n_pend      = r_pend;
        n_have_pend = r_have_pend;
        if (r_src_enc) begin
            job.cp_a  = cp1252_to_cp(i_in_data.in_byte);
            job.has_a = 1'b1;
        end else if (!r_have_low) begin
            n_held_low = i_in_data.in_byte;
            n_have_low = 1'b1;
            if (last && r_have_pend) begin
                job.cp_a  = pend_cp;
                job.has_a = 1'b1;
            end
        end else begin
            n_have_low = 1'b0;
            if (r_have_pend && is_lo) begin
                job.cp_a    = comb_cp;
                job.has_a   = 1'b1;
                n_have_pend = 1'b0;
            end else if (r_have_pend) begin
                job.cp_a    = pend_cp;
                job.has_a   = 1'b1;
                n_have_pend = 1'b0;
                if (is_hi && !last) begin
                    n_pend      = unit[9:0];
                    n_have_pend = 1'b1;
                end else begin
                    job.cp_b  = {5'b0, unit};
                    job.has_b = 1'b1;
                end
            end else if (is_hi && !last) begin
                n_pend      = unit[9:0];
                n_have_pend = 1'b1;
            end else begin
                job.cp_a  = {5'b0, unit};
                job.has_a = 1'b1;
            end
        end
        if (last) begin
            n_have_low  = 1'b0;
            n_have_pend = 1'b0;
        end
    end

    assign o_q_push = accept && (job.has_a || job.last);
    assign o_q_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_enc   <= 1'b0;
            r_have_low  <= 1'b0;
            r_have_pend <= 1'b0;
        end else if (i_cfg_we) begin
            r_src_enc   <= i_cfg_wdata;
            r_have_low  <= 1'b0;
            r_have_pend <= 1'b0;
        end else if (accept) begin
            r_have_low  <= n_have_low;
            r_have_pend <= n_have_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held_low <= n_held_low;
            r_pend     <= n_pend;
        end
    end

endmodule

// ===== design/utc_queue.sv =====
module utc_queue import utc_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    localparam int AW = $clog2(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [AW:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = r_cnt == (AW+1)'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

// ===== design/utc_back.sv =====
module utc_back import utc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_job      i_q_job,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_job       r_job;
    logic       r_busy;
    logic       r_sel;
    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_item  r_out;

    logic [CP_W-1:0] cur_cp;
    logic [1:0]      len_m1;
    logic            bare;
    logic            cp_end;
    logic            job_done;
    logic            out_free;
    logic            emit;
    logic            take;
    t_out_item       n_out;

    assign cur_cp   = r_sel ? r_job.cp_b : r_job.cp_a;
    assign len_m1   = utf8_len_m1(cur_cp);
    assign bare     = !r_job.has_a;
    assign cp_end   = r_idx == len_m1;
    assign job_done = bare || (cp_end && (r_sel || !r_job.has_b));
    assign out_free = !r_out_valid || i_out_ready;
    assign emit     = r_busy && out_free;
    assign take     = !i_q_empty && (!r_busy || (emit && job_done));
    assign o_q_pop  = take;

    always_comb begin
        n_out.out_byte   = bare ? 8'h00 : utf8_byte(cur_cp, r_idx);
        n_out.byte_valid = !bare;
        n_out.last_out   = r_job.last && job_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_sel       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (take) begin
                r_busy <= 1'b1;
                r_sel  <= 1'b0;
                r_idx  <= '0;
            end else if (emit && job_done) begin
                r_busy <= 1'b0;
            end else if (emit && cp_end) begin
                r_sel <= 1'b1;
                r_idx <= '0;
            end else if (emit) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_q_job;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== design/utf16le_cp1252_to_utf8.sv =====
// Byte-serial transcoder from UTF-16LE or CP1252 to UTF-8. Write the source
// encoding (0 = UTF-16LE, 1 = CP1252) only between strings; a write also
// drops any half unit or held high surrogate. Each request carries one source
// byte and a last flag; each response carries one UTF-8 byte, or a bare end
// marker (byte_valid = 0) when the last request produced nothing. The front
// stage takes one request per cycle while the job queue has room and turns it
// into at most two code points; the back stage serializes one UTF-8 byte per
// cycle into the output register while the output is not stalled. A request
// yields one to six UTF-8 bytes or a bare end marker, and one that only
// completes half of a unit gives the back stage no work. Sustained rate is
// one output byte per cycle while the output is not stalled.
module utf16le_cp1252_to_utf8 import utc_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic q_full;
    logic q_push;
    t_job q_wjob;
    logic q_empty;
    logic q_pop;
    t_job q_rjob;

    utc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_job    (q_wjob)
    );

    utc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (q_wjob),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_job  (q_rjob)
    );

    utc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_job    (q_rjob),
        .o_q_pop    (q_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule

// ===== design/utc_checker.sv =====
module utc_checker import utc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // response held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("response changed while stalled");

    // a bare marker is always the end of a string and carries a zero byte
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.byte_valid |->
            o_out_data.last_out && o_out_data.out_byte == 8'h00)
        else $error("bare marker without last or with data");

    // no byte above the largest 4-byte lead
    a_byte_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.byte_valid |->
            o_out_data.out_byte[7:3] != 5'b11111)
        else $error("invalid UTF-8 byte");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid after reset");

endmodule

bind utf16le_cp1252_to_utf8 utc_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
